/* rtl/mac_learning_table_macros.svh */
// Assertion macros for the MAC learning table.
`ifndef MAC_LEARNING_TABLE_MACROS_SVH
`define MAC_LEARNING_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define MLT_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("mac learning table check failed");
`define MLT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("mac learning table check failed");
`else
`define MLT_ASSERT_SAME(label, clk, rst, a, c)
`define MLT_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* rtl/mlt_pkg.sv */
package mlt_pkg;

  localparam int MLT_ENTRIES = 256;

  localparam logic [15:0] MIN_LEN_RESET = 16'd14;
  localparam logic [31:0] TIMEOUT_RESET = 32'd60;

  localparam logic [1:0] CFG_MIN_LEN = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;

  localparam logic OP_LEARN  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] KIND_INVALID   = 2'd0;
  localparam logic [1:0] KIND_BROADCAST = 2'd1;
  localparam logic [1:0] KIND_UNICAST   = 2'd2;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] port_id;
    logic [31:0] port_stamp;
    logic [31:0] learn_time;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

/* rtl/mac_learning_table.sv */
// MAC learning table with aging.
// Command port: an item is taken on a clock edge where start is high and busy
// is low. opcode 0 learns mac_address with port_id, port_stamp and
// current_time; opcode 1 looks up mac_address and yields one result word.
// Results appear on frame_kind, found_port_id and found_port_stamp for one
// cycle with result_valid high; the receiver cannot stall them.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 minimum frame length, 1 entry timeout); other indexes are ignored.
// Scan: entries are held in one single-port-read RAM and scanned one per
// cycle; an item holds busy while it reads the N entries learned so far
// (at most ENTRIES). A lookup that hits stops early.
// Short lookups and lookups on an empty table answer in the cycle after start.
// Ignored learns (short or multicast) never raise busy.
// Reset: clears the fill count, so the table is empty; registers return to
// minimum length 14 and timeout 60. No clearing pass is needed.
module mac_learning_table #(
  parameter int ENTRIES = mlt_pkg::MLT_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [47:0] mac_address,
  input  logic [15:0] frame_length,
  input  logic [31:0] port_id,
  input  logic [31:0] port_stamp,
  input  logic [31:0] current_time,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  frame_kind,
  output logic [31:0] found_port_id,
  output logic [31:0] found_port_stamp
);
  import mlt_pkg::*;

  localparam int AW = $clog2(ENTRIES);

  logic [15:0] min_len;
  logic [31:0] timeout;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RESET;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_LEN: min_len <= cfg_data[15:0];
        CFG_TIMEOUT: timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  mlt_engine #(.ENTRIES(ENTRIES)) u_engine (
    .clk, .rst, .start, .busy, .opcode, .mac_address, .frame_length,
    .port_id, .port_stamp, .current_time,
    .min_len, .timeout,
    .result_valid, .frame_kind, .found_port_id, .found_port_stamp,
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  mlt_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk,
    .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

endmodule

/* rtl/mlt_mem.sv */
module mlt_mem #(
  parameter int ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  mlt_pkg::entry_t            wdata,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output mlt_pkg::entry_t            rdata
);
  import mlt_pkg::*;

  entry_t mem [ENTRIES];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mlt_engine.sv */
`include "mac_learning_table_macros.svh"

module mlt_engine #(
  parameter int ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode,
  input  logic [47:0]                mac_address,
  input  logic [15:0]                frame_length,
  input  logic [31:0]                port_id,
  input  logic [31:0]                port_stamp,
  input  logic [31:0]                current_time,
  input  logic [15:0]                min_len,
  input  logic [31:0]                timeout,
  output logic                       result_valid,
  output logic [1:0]                 frame_kind,
  output logic [31:0]                found_port_id,
  output logic [31:0]                found_port_stamp,
  output logic                       mem_we,
  output logic [$clog2(ENTRIES)-1:0] mem_waddr,
  output mlt_pkg::entry_t            mem_wdata,
  output logic [$clog2(ENTRIES)-1:0] mem_raddr,
  input  mlt_pkg::entry_t            mem_rdata
);
  import mlt_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic          res_vld, res_vld_next;
  logic [1:0]    kind, kind_next;
  logic [31:0]   res_pid, res_pid_next;
  logic [31:0]   res_pts, res_pts_next;

  logic          item_op;
  logic [47:0]   item_mac;
  logic [31:0]   item_pid, item_pts, item_now;

  logic [CW-1:0] iss, iss_next;
  logic          iss_act, iss_act_next;
  logic          chk_vld, chk_vld_next;
  logic [CW-1:0] chk, chk_next;
  logic          found, found_next;
  logic [CW-1:0] match_idx, match_next;
  logic [CW-1:0] best_idx, best_next;
  logic [31:0]   best_age, best_age_next;

  logic          accept, long_enough;
  logic          hit, last;
  logic [31:0]   age;
  logic [CW-1:0] slot;

  assign accept      = start && (state == ST_IDLE);
  assign long_enough = frame_length > min_len;
  assign age         = item_now - mem_rdata.learn_time;
  assign hit         = mem_rdata.mac == item_mac;
  assign last        = (chk + CW'(1)) == count;
  assign slot        = found ? match_idx : ((count == FULL) ? best_idx : count);

  assign busy             = state != ST_IDLE;
  assign result_valid     = res_vld;
  assign frame_kind       = kind;
  assign found_port_id    = res_pid;
  assign found_port_stamp = res_pts;

  assign mem_raddr = iss[AW-1:0];
  assign mem_waddr = slot[AW-1:0];
  assign mem_we    = state == ST_WRITE;
  assign mem_wdata = '{mac: item_mac, port_id: item_pid, port_stamp: item_pts,
                       learn_time: item_now};

  // Next state, scan bookkeeping and result
  always_comb begin
    state_next    = state;
    count_next    = count;
    res_vld_next  = 1'b0;
    kind_next     = kind;
    res_pid_next  = res_pid;
    res_pts_next  = res_pts;
    iss_next      = iss;
    iss_act_next  = iss_act;
    chk_vld_next  = 1'b0;
    chk_next      = chk;
    found_next    = found;
    match_next    = match_idx;
    best_next     = best_idx;
    best_age_next = best_age;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          iss_next     = '0;
          iss_act_next = 1'b1;
          found_next   = 1'b0;
          if (opcode == OP_LOOKUP) begin
            res_pid_next = '0;
            res_pts_next = '0;
            if (!long_enough) begin
              res_vld_next = 1'b1;
              kind_next    = KIND_INVALID;
            end else if (count == '0) begin
              res_vld_next = 1'b1;
              kind_next    = KIND_BROADCAST;
            end else begin
              state_next = ST_SCAN;
            end
          end else if (long_enough && !mac_address[40]) begin
            state_next = (count == '0) ? ST_WRITE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue the next read
        if (iss_act) begin
          chk_vld_next = 1'b1;
          chk_next     = iss;
          iss_next     = iss + CW'(1);
          iss_act_next = (iss + CW'(1)) < count;
        end
        // Check the entry read last cycle
        if (chk_vld) begin
          if (item_op == OP_LOOKUP) begin
            if (hit || last) begin
              state_next   = ST_IDLE;
              res_vld_next = 1'b1;
              kind_next    = KIND_BROADCAST;
              if (hit && (age < timeout)) begin
                kind_next    = KIND_UNICAST;
                res_pid_next = mem_rdata.port_id;
                res_pts_next = mem_rdata.port_stamp;
              end
            end
          end else begin
            if (hit && !found) begin
              found_next = 1'b1;
              match_next = chk;
            end
            if ((chk == '0) || (age > best_age)) begin
              best_next     = chk;
              best_age_next = age;
            end
            if (last) begin
              state_next = ST_WRITE;
            end
          end
        end
      end
      ST_WRITE: begin
        state_next = ST_IDLE;
        if (slot == count) begin
          count_next = count + CW'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      res_vld <= 1'b0;
      iss_act <= 1'b0;
      chk_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      res_vld <= res_vld_next;
      iss_act <= iss_act_next;
      chk_vld <= chk_vld_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    kind      <= kind_next;
    res_pid   <= res_pid_next;
    res_pts   <= res_pts_next;
    iss       <= iss_next;
    chk       <= chk_next;
    found     <= found_next;
    match_idx <= match_next;
    best_idx  <= best_next;
    best_age  <= best_age_next;
    if (accept) begin
      item_op  <= opcode;
      item_mac <= mac_address;
      item_pid <= port_id;
      item_pts <= port_stamp;
      item_now <= current_time;
    end
  end

  `MLT_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= FULL)
  `MLT_ASSERT_SAME(a_result_after_work, clk, rst, res_vld, $past(state == ST_IDLE ? start : 1'b1))
  `MLT_ASSERT_NEXT(a_count_step, clk, rst, state == ST_WRITE,
    (count == $past(count)) || (count == $past(count) + CW'(1)))

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlt_pkg::*;

  localparam int N = MLT_ENTRIES;
  localparam int LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode = OP_LEARN;
  logic [47:0] mac_address = '0;
  logic [15:0] frame_length = '0;
  logic [31:0] port_id = '0;
  logic [31:0] port_stamp = '0;
  logic [31:0] current_time = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        result_valid;
  logic [1:0]  frame_kind;
  logic [31:0] found_port_id;
  logic [31:0] found_port_stamp;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] pid;
    logic [31:0] pts;
  } answer_t;

  // model copy of the table and registers
  logic [15:0] min_len;
  logic [31:0] timeout;
  logic        tbl_valid [N];
  logic [47:0] tbl_mac [N];
  logic [31:0] tbl_pid [N];
  logic [31:0] tbl_pts [N];
  logic [31:0] tbl_time [N];

  answer_t answers_due[$];
  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int answers_seen = 0;
  int unicast_seen = 0;
  int send_idle = 0;

  // up to 200 learned MACs, reused for hits
  logic [47:0] known_macs[$];
  logic [31:0] now_base = 32'd1000;

  mac_learning_table uut (.*);

  always #5 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[mac_learning_table] ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h (answer %0d)", what, got, want, answers_seen);
    errors++;
  endtask

  // check each result word against the oldest expected answer
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (answers_due.size() == 0) begin
        report("unexpected word", {30'd0, frame_kind}, 32'd0);
      end else begin
        answer_t a;
        a = answers_due.pop_front();
        if (frame_kind !== a.kind) report("frame_kind", {30'd0, frame_kind}, {30'd0, a.kind});
        if (found_port_id !== a.pid) report("found_port_id", found_port_id, a.pid);
        if (found_port_stamp !== a.pts) report("found_port_stamp", found_port_stamp, a.pts);
        if (frame_kind === KIND_UNICAST) unicast_seen++;
      end
      answers_seen++;
    end
  end

  function automatic int find_mac(input logic [47:0] mac);
    for (int i = 0; i < N; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  // update the table model and predict the answer of one word
  task automatic predict_word(input logic op, input logic [47:0] mac, input logic [15:0] len,
                              input logic [31:0] pid, input logic [31:0] pts,
                              input logic [31:0] now);
    int s;
    logic [31:0] age, best_age;
    answer_t a;
    if (op == OP_LEARN) begin
      if (len > min_len && !mac[40]) begin
        s = find_mac(mac);
        if (s < 0)
          for (int i = 0; i < N; i++)
            if (!tbl_valid[i]) begin
              s = i;
              break;
            end
        if (s < 0) begin
          s = 0;
          best_age = now - tbl_time[0];
          for (int i = 1; i < N; i++) begin
            age = now - tbl_time[i];
            if (age > best_age) begin
              best_age = age;
              s = i;
            end
          end
        end
        tbl_valid[s] = 1'b1;
        tbl_mac[s] = mac;
        tbl_pid[s] = pid;
        tbl_pts[s] = pts;
        tbl_time[s] = now;
      end
    end else begin
      a = '{KIND_INVALID, 32'd0, 32'd0};
      if (len > min_len) begin
        a.kind = KIND_BROADCAST;
        s = find_mac(mac);
        if (s >= 0 && (now - tbl_time[s]) < timeout)
          a = '{KIND_UNICAST, tbl_pid[s], tbl_pts[s]};
      end
      answers_due.push_back(a);
    end
  endtask

  // send one command word, with optional idle cycles before it
  task automatic send_word(input logic op, input logic [47:0] mac, input logic [15:0] len,
                           input logic [31:0] pid, input logic [31:0] pts,
                           input logic [31:0] now);
    while ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(negedge clk);
    end
    opcode <= op;
    mac_address <= mac;
    frame_length <= len;
    port_id <= pid;
    port_stamp <= pts;
    current_time <= now;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(op, mac, len, pid, pts, now);
    words_sent++;
    @(negedge clk);
  endtask

  // wait until every answer is in, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (N + 8) @(negedge clk);
  endtask

  // write one register once nothing is in flight
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    start <= 1'b0;
    while (busy || answers_due.size() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_LEN) min_len = val[15:0];
    else if (idx == CFG_TIMEOUT) timeout = val;
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [47:0] m;
    m = 48'h0200_0000_0001;
    // lookup on empty table, short lookup, extremes of length
    send_word(OP_LOOKUP, m, 16'd15, '1, '1, 32'd0);
    send_word(OP_LOOKUP, m, 16'd14, 32'd0, 32'd0, 32'd0);
    send_word(OP_LOOKUP, '1, 16'hFFFF, 32'd0, 32'd0, 32'd0);
    // learn then hit
    send_word(OP_LEARN, m, 16'd15, 32'hDEAD_BEEF, 32'h1234_5678, 32'd100);
    send_word(OP_LOOKUP, m, 16'hFFFF, 32'd0, 32'd0, 32'd159);
    // stale on lookup
    send_word(OP_LOOKUP, m, 16'd20, 32'd0, 32'd0, 32'd160);
    // multicast and short learns are ignored
    send_word(OP_LEARN, 48'h0100_0000_0002, 16'd100, 32'd1, 32'd1, 32'd100);
    send_word(OP_LOOKUP, 48'h0100_0000_0002, 16'd100, 32'd0, 32'd0, 32'd101);
    send_word(OP_LEARN, 48'h0200_0000_0003, 16'd14, 32'd1, 32'd1, 32'd100);
    send_word(OP_LOOKUP, 48'h0200_0000_0003, 16'd100, 32'd0, 32'd0, 32'd101);
    // overwrite a matching entry, wrap of time
    send_word(OP_LEARN, m, 16'd64, '1, '1, 32'hFFFF_FFF0);
    send_word(OP_LOOKUP, m, 16'd64, 32'd0, 32'd0, 32'd5);
    // all-zero and top unicast MAC
    send_word(OP_LEARN, 48'd0, 16'd64, 32'd7, 32'd8, 32'd5);
    send_word(OP_LOOKUP, 48'd0, 16'd64, 32'd0, 32'd0, 32'd6);
    send_word(OP_LEARN, 48'hFEFF_FFFF_FFFF, 16'hFFFF, 32'd9, 32'd10, 32'd5);
    send_word(OP_LOOKUP, 48'hFEFF_FFFF_FFFF, 16'd64, 32'd0, 32'd0, 32'd6);
    drain();
    // zero timeout and maximum minimum length
    write_reg(CFG_TIMEOUT, 32'd0);
    send_word(OP_LOOKUP, m, 16'd64, 32'd0, 32'd0, 32'd5);
    write_reg(CFG_MIN_LEN, 32'h0000_FFFF);
    send_word(OP_LOOKUP, m, 16'hFFFF, 32'd0, 32'd0, 32'd5);
    send_word(OP_LEARN, 48'h0200_0000_0009, 16'hFFFF, 32'd1, 32'd1, 32'd5);
    drain();
    // unknown register index is ignored
    write_reg(2'd3, 32'd5);
    write_reg(CFG_MIN_LEN, 32'd0);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, m, 16'd1, 32'd0, 32'd0, 32'd6);
    send_word(OP_LOOKUP, 48'hFEFF_FFFF_FFFF, 16'd1, 32'd0, 32'd0, 32'd0);
    drain();
  endtask

  // fill the table beyond its size so replacement and age ties occur
  task automatic test_replacement();
    write_reg(CFG_MIN_LEN, 32'd14);
    write_reg(CFG_TIMEOUT, 32'd5000);
    for (int i = 0; i < N + 20; i++)
      send_word(OP_LEARN, {8'h02, 8'hA0, 32'(i)}, 16'd64, $urandom, $urandom,
                now_base + 32'(i / 3));
    for (int i = 0; i < 40; i++)
      send_word(OP_LOOKUP, {8'h02, 8'hA0, 32'($urandom_range(N + 19))}, 16'd64, 32'd0, 32'd0,
                now_base + 32'(N / 3 + 10));
    drain();
  endtask

  function automatic logic [47:0] pick_mac();
    logic [47:0] r;
    if (known_macs.size() != 0 && $urandom_range(99) < 65)
      return known_macs[$urandom_range(known_macs.size() - 1)];
    if ($urandom_range(9) == 0) r = 48'({$urandom, $urandom});
    else r = {8'h02, 32'hB000_0000, 8'($urandom_range(63))};
    return r;
  endfunction

  // random mix of learns and lookups on a small set of MACs
  task automatic test_random(input int count);
    logic [47:0] mac;
    logic [15:0] len;
    logic [31:0] tmo;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) begin
        drain();
        case ($urandom_range(4))
          0: tmo = 32'd0;
          1: tmo = 32'hFFFF_FFFF;
          default: tmo = $urandom_range(200, 10);
        endcase
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_MIN_LEN, ($urandom_range(7) == 0) ? 32'h0000_FFFF : $urandom_range(60));
      end
      mac = pick_mac();
      len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1518, 40));
      now_base += $urandom_range(15);
      if ($urandom_range(1)) begin
        send_word(OP_LEARN, mac, len, $urandom, $urandom, now_base);
        if (known_macs.size() < 200) known_macs.push_back(mac);
      end else begin
        send_word(OP_LOOKUP, mac, len, 32'd0, 32'd0, now_base);
      end
    end
    drain();
  endtask

  initial begin
    min_len = MIN_LEN_RESET;
    timeout = TIMEOUT_RESET;
    for (int i = 0; i < N; i++) tbl_valid[i] = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_replacement();
    send_idle = 24;
    test_random(450);
    send_idle = 54;
    test_random(450);
    send_idle = 0;
    test_random(450);
    $display("sent %0d words, checked %0d answers, %0d unicast hits", words_sent,
             answers_seen, unicast_seen);
    if (errors == 0) begin
      $display("[mac_learning_table] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[mac_learning_table] ERROR");
    end
    $finish;
  end
endmodule
